// File: src/preamble_timing_metric_defines.svh
// Assertion macros for the preamble timing metric block.
`ifndef PREAMBLE_TIMING_METRIC_DEFINES_SVH
`define PREAMBLE_TIMING_METRIC_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define PTM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define PTM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);
`else
`define PTM_ASSERT_IMP(lbl, ck, rs, ante, cons, msg)
`define PTM_ASSERT_NXT(lbl, ck, rs, ante, cons, msg)
`endif
`endif

// File: src/ptm_pkg.sv
// Shared types and constants for the preamble timing metric block.
`default_nettype none
package ptm_pkg;
  localparam int MAX_BLOCK   = 512;
  localparam int DEPTH       = MAX_BLOCK + 1;
  localparam int ADDR_W      = 10;
  localparam int SAMPLE_BITS = 16;
  localparam int WORD_W      = 2 * SAMPLE_BITS;
  localparam int CORR_W      = 42;
  localparam int EN_W        = 41;
  localparam int SQ_W        = 84;
  localparam int DIV_W       = 107;
  localparam int METRIC_W    = 24;
  localparam int CNT_W       = 10;
  localparam int SQ_STEPS    = 9;
  localparam int DIV_STEPS   = METRIC_W + 1;

  localparam logic [1:0] METHOD_SC   = 2'd0;
  localparam logic [1:0] METHOD_MINN = 2'd1;
  localparam logic [1:0] METHOD_PARK = 2'd2;

  localparam logic [1:0] REG_METHOD       = 2'd0;
  localparam logic [1:0] REG_PREAMBLE_LEN = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SUM, ST_DRAIN, ST_SQ, ST_SQ_WAIT, ST_DIV_INIT, ST_DIV, ST_DONE
  } state_t;

  typedef struct packed {
    logic             accept;
    logic             clr_acc;
    logic             issue;
    logic             park_shift;
    logic             sq_issue;
    logic             div_init;
    logic             div_step;
    logic             div_first;
    logic             load;
    logic [CNT_W-1:0] cnt;
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       fill_last;
    logic       park;
    logic [8:0] half;
    logic       busy;
    logic       energy_zero;
    logic       out_busy;
  } sts_t;
endpackage
`default_nettype wire

// File: src/ptm_ctrl.sv
// Sequencer for the preamble timing metric: fill, sums, squares, divide, hand-off.
`default_nettype none
module ptm_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire ptm_pkg::sts_t sts,
  output      ptm_pkg::cmd_t cmd
);
  import ptm_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.cnt    = cnt;
    in_ready   = 1'b0;
    go         = sts.full || (sts.fill_last && !sts.park);
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (go) begin
            cmd.clr_acc = 1'b1;
            cnt_next    = '0;
            state_next  = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        cmd.issue = 1'b1;
        if (cnt == {1'b0, sts.half} - CNT_W'(1)) begin
          state_next = ST_DRAIN;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_DRAIN: begin
        if (!sts.busy) begin
          cmd.park_shift = sts.park;
          cnt_next       = '0;
          state_next     = sts.energy_zero ? ST_DONE : ST_SQ;
        end
      end
      ST_SQ: begin
        cmd.sq_issue = 1'b1;
        if (cnt == CNT_W'(SQ_STEPS - 1)) begin
          state_next = ST_SQ_WAIT;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_SQ_WAIT: state_next = ST_DIV_INIT;
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        cnt_next     = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step  = 1'b1;
        cmd.div_first = (cnt == '0);
        if (cnt == CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_DONE;
        end else begin
          cnt_next = cnt + CNT_W'(1);
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// File: src/ptm_datapath.sv
// Window memory, correlation accumulators, squaring unit, divider and result register.
`default_nettype none
module ptm_datapath (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [9:0]                          cfg_data,
  input  wire logic signed [ptm_pkg::SAMPLE_BITS-1:0] sample_re,
  input  wire logic signed [ptm_pkg::SAMPLE_BITS-1:0] sample_im,
  input  wire ptm_pkg::cmd_t                       cmd,
  output      ptm_pkg::sts_t                       sts,
  output      logic                                out_valid,
  input  wire logic                                out_ready,
  output      logic [ptm_pkg::METRIC_W-1:0]        metric,
  output      logic                                zero_energy
);
  import ptm_pkg::*;

  function automatic logic [ADDR_W-1:0] wrap(input logic [ADDR_W-1:0] base,
                                             input logic [ADDR_W-1:0] off);
    logic [ADDR_W:0] s;
    s = {1'b0, base} + {1'b0, off};
    if (s >= (ADDR_W+1)'(DEPTH)) s = s - (ADDR_W+1)'(DEPTH);
    return s[ADDR_W-1:0];
  endfunction

  // configuration
  logic [1:0]        method;
  logic [9:0]        preamble_len;
  logic [9:0]        n_clamp, n_eff, need;
  logic [8:0]        half;
  logic [7:0]        quart;
  logic              park, conj;

  always_comb begin
    n_clamp = preamble_len;
    if (preamble_len < 10'd4) n_clamp = 10'd4;
    if (preamble_len > 10'(MAX_BLOCK)) n_clamp = 10'(MAX_BLOCK);
    n_eff = (method == METHOD_MINN) ? {n_clamp[9:2], 2'b00} : {n_clamp[9:1], 1'b0};
    park  = (method == METHOD_PARK);
    conj  = !park;
    half  = n_eff[9:1];
    quart = n_eff[9:2];
    need  = park ? n_eff + 10'd1 : n_eff;
  end

  // window bookkeeping
  logic [ADDR_W-1:0]  fill, head;
  logic [WORD_W-1:0]  s_hold;
  logic               full;
  logic               we;
  logic [ADDR_W-1:0]  waddr;
  logic [WORD_W-1:0]  wdata;
  logic [WORD_W-1:0]  mem [0:DEPTH-1];

  assign full = (fill >= need);

  always_ff @(posedge clk) begin
    if (rst) begin
      method       <= METHOD_SC;
      preamble_len <= 10'd64;
      fill         <= '0;
      head         <= '0;
    end else if (cfg_we && (cfg_index == REG_METHOD || cfg_index == REG_PREAMBLE_LEN)) begin
      if (cfg_index == REG_METHOD) method <= cfg_data[1:0];
      else                         preamble_len <= cfg_data;
      fill <= '0;
      head <= '0;
    end else begin
      if (cmd.accept && !full) fill <= fill + ADDR_W'(1);
      if ((cmd.accept && full && !park) || cmd.park_shift) head <= wrap(head, ADDR_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) s_hold <= {sample_re, sample_im};
  end

  always_comb begin
    we    = 1'b0;
    waddr = wrap(head, fill);
    wdata = {sample_re, sample_im};
    if (cmd.accept && !full) begin
      we = 1'b1;
    end else if (cmd.accept && !park) begin
      we    = 1'b1;
      waddr = wrap(head, need);
    end else if (cmd.park_shift) begin
      we    = 1'b1;
      waddr = wrap(head, need);
      wdata = s_hold;
    end
  end

  // pair addresses
  logic [ADDR_W-1:0] oa, ob, j;
  logic [WORD_W-1:0] rda, rdb;
  assign j = cmd.cnt;

  always_comb begin
    unique case (method)
      METHOD_MINN: begin
        if (j < {2'b00, quart}) begin
          oa = j;
          ob = j + {2'b00, quart};
        end else begin
          oa = j + {2'b00, quart};
          ob = j + {1'b0, quart, 1'b0};
        end
      end
      METHOD_PARK: begin
        oa = {1'b0, half} - ADDR_W'(1) - j;
        ob = {1'b0, half} + j;
      end
      default: begin
        oa = j;
        ob = j + {1'b0, half};
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd.issue) begin
      rda <= mem[wrap(head, oa)];
      rdb <= mem[wrap(head, ob)];
    end
  end

  // products and accumulation
  logic                          v1, v2, conj2;
  logic signed [WORD_W-1:0]      p_rr, p_ii, p_ri, p_ir, p_bb, p_bi;
  logic signed [CORR_W-1:0]      cre, cim;
  logic [EN_W-1:0]               en;
  logic signed [SAMPLE_BITS-1:0] a_re, a_im, b_re, b_im;

  assign a_re = signed'(rda[WORD_W-1:SAMPLE_BITS]);
  assign a_im = signed'(rda[SAMPLE_BITS-1:0]);
  assign b_re = signed'(rdb[WORD_W-1:SAMPLE_BITS]);
  assign b_im = signed'(rdb[SAMPLE_BITS-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.issue;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    conj2 <= conj;
    p_rr  <= a_re * b_re;
    p_ii  <= a_im * b_im;
    p_ri  <= a_re * b_im;
    p_ir  <= a_im * b_re;
    p_bb  <= b_re * b_re;
    p_bi  <= b_im * b_im;
    if (cmd.clr_acc) begin
      cre <= '0;
      cim <= '0;
      en  <= '0;
    end else if (v2) begin
      if (conj2) begin
        cre <= cre + CORR_W'(p_rr) + CORR_W'(p_ii);
        cim <= cim + CORR_W'(p_ri) - CORR_W'(p_ir);
      end else begin
        cre <= cre + CORR_W'(p_rr) - CORR_W'(p_ii);
        cim <= cim + CORR_W'(p_ri) + CORR_W'(p_ir);
      end
      en <= en + EN_W'(unsigned'(p_bb)) + EN_W'(unsigned'(p_bi));
    end
  end

  // squares through one 21x21 multiplier, three partial products each
  logic [CORR_W-1:0] mag_re, mag_im, opnd;
  logic [20:0]       ma, mb;
  logic [1:0]        part;
  logic              to_den;
  logic [41:0]       prod;
  logic [1:0]        psh;
  logic              pden, pv;
  logic [SQ_W-1:0]   num, den, addend;

  assign mag_re = cre[CORR_W-1] ? unsigned'(-cre) : unsigned'(cre);
  assign mag_im = cim[CORR_W-1] ? unsigned'(-cim) : unsigned'(cim);

  always_comb begin
    opnd   = mag_re;
    part   = 2'd0;
    to_den = 1'b0;
    unique case (cmd.cnt[3:0])
      4'd0: begin opnd = mag_re; part = 2'd0; end
      4'd1: begin opnd = mag_re; part = 2'd1; end
      4'd2: begin opnd = mag_re; part = 2'd2; end
      4'd3: begin opnd = mag_im; part = 2'd0; end
      4'd4: begin opnd = mag_im; part = 2'd1; end
      4'd5: begin opnd = mag_im; part = 2'd2; end
      4'd6: begin opnd = {1'b0, en}; part = 2'd0; to_den = 1'b1; end
      4'd7: begin opnd = {1'b0, en}; part = 2'd1; to_den = 1'b1; end
      4'd8: begin opnd = {1'b0, en}; part = 2'd2; to_den = 1'b1; end
      default: begin opnd = mag_re; part = 2'd0; end
    endcase
    ma = (part == 2'd2) ? opnd[41:21] : opnd[20:0];
    mb = (part == 2'd0) ? opnd[20:0]  : opnd[41:21];
  end

  always_comb begin
    unique case (psh)
      2'd1:    addend = SQ_W'(prod) << 22;
      2'd2:    addend = SQ_W'(prod) << 42;
      default: addend = SQ_W'(prod);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) pv <= 1'b0;
    else     pv <= cmd.sq_issue;
    prod <= 42'(ma) * 42'(mb);
    psh  <= part;
    pden <= to_den;
    if (cmd.clr_acc) begin
      num <= '0;
      den <= '0;
    end else if (pv) begin
      if (pden) den <= den + addend;
      else      num <= num + addend;
    end
  end

  // restoring divider, one quotient bit a step; the first step tests saturation
  logic [DIV_W-1:0]    rem, dsh;
  logic [METRIC_W-1:0] quo;
  logic                sat, ge;

  assign ge = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem <= DIV_W'(num) << 16;
      dsh <= DIV_W'(den) << 24;
      quo <= '0;
    end else if (cmd.div_step) begin
      if (ge) rem <= rem - dsh;
      dsh <= dsh >> 1;
      quo <= {quo[METRIC_W-2:0], ge};
      if (cmd.div_first) sat <= ge;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (cmd.load) begin
      zero_energy <= (en == '0);
      metric      <= ((en == '0) || sat) ? '1 : quo;
    end
  end

  always_comb begin
    sts             = '0;
    sts.full        = full;
    sts.fill_last   = (fill + ADDR_W'(1) == need);
    sts.park        = park;
    sts.half        = half;
    sts.busy        = v1 || v2;
    sts.energy_zero = (en == '0);
    sts.out_busy    = out_valid && !out_ready;
  end
endmodule
`default_nettype wire

// File: src/preamble_timing_metric.sv
// Top level of the preamble timing metric (Schmidl-Cox, Minn, Park).
//
//  Channel  Signals                              Direction  Transfer when
//  input    in_valid/in_ready, sample_re/_im     in         in_valid & in_ready
//  output   out_valid/out_ready, metric, zero_e. out        out_valid & out_ready
//  config   cfg_we, cfg_index, cfg_data          in         cfg_we (no wait)
//
//  A sample that only fills the window leaves the sequencer idle. A sample
//  that yields a metric runs from its transfer to the next ready through an
//  accept, N/2 pair reads from the two-port window memory, a pipeline drain,
//  nine squaring steps on one 21x21 multiplier plus a settling state, one
//  divider load, a 25-step restoring divider and one hand-off.
//  A zero energy skips squaring and division.
//  Reset is synchronous, active high; it restores method 0, N = 64 and an
//  empty window. The result register lets the next sample transfer while a
//  metric still waits; a stalled output only holds the sequencer at hand-off.
`default_nettype none
`include "preamble_timing_metric_defines.svh"
module preamble_timing_metric (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [1:0]                             cfg_index,
  input  wire logic [9:0]                             cfg_data,
  input  wire logic                                   in_valid,
  output      logic                                   in_ready,
  input  wire logic signed [ptm_pkg::SAMPLE_BITS-1:0] sample_re,
  input  wire logic signed [ptm_pkg::SAMPLE_BITS-1:0] sample_im,
  output      logic                                   out_valid,
  input  wire logic                                   out_ready,
  output      logic [ptm_pkg::METRIC_W-1:0]           metric,
  output      logic                                   zero_energy
);
  import ptm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer: decides when to sum, square, divide and hand the result over
  ptm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath: window store, accumulators, squarer, divider, result register
  ptm_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_re   (sample_re),
    .sample_im   (sample_im),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .metric      (metric),
    .zero_energy (zero_energy)
  );

  // the product pipeline must be empty whenever a new sample may transfer
  `PTM_ASSERT_IMP(a_idle_pipe_empty, clk, rst, in_ready, !sts.busy, "pipeline busy while idle")
  // loading a result always presents it the next cycle
  `PTM_ASSERT_NXT(a_load_shows, clk, rst, cmd.load, out_valid, "loaded result not shown")
  // zero energy forces the saturated metric
  `PTM_ASSERT_IMP(a_zero_max, clk, rst, out_valid && zero_energy, metric == '1, "zero energy metric")
endmodule
`default_nettype wire

// File: tb/sv/ptm_metric_checker.sv
// Checker: predicts each timing metric from input transfers and compares results.
`timescale 1ns / 1ps
module ptm_metric_checker
  import ptm_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [9:0]                    cfg_data,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] sample_re,
  input  logic signed [SAMPLE_BITS-1:0] sample_im,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [METRIC_W-1:0]           metric,
  input  logic                          zero_energy,
  output int                            fail_count,
  output int                            pending
);

  typedef struct packed {
    logic [METRIC_W-1:0] value;
    logic                zero;
  } metric_t;

  metric_t                   awaited_metrics[$];
  logic [1:0]                method_q;
  logic [9:0]                size_q;
  int                        fill_q;
  logic signed [SAMPLE_BITS-1:0] win_re[0:MAX_BLOCK];
  logic signed [SAMPLE_BITS-1:0] win_im[0:MAX_BLOCK];

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // effective N: clamp, then round down to a multiple of 4 (Minn) or 2
  function automatic int block_len();
    int n;
    n = size_q;
    if (n < 4) n = 4;
    if (n > MAX_BLOCK) n = MAX_BLOCK;
    return (method_q == METHOD_MINN) ? (n & ~3) : (n & ~1);
  endfunction

  function automatic metric_t window_metric(int n);
    longint       pr, pi, en, ar, ai, br, bi;
    int           l, segs, a, b;
    bit           park;
    logic [127:0] ur, ui, num, den, q;
    metric_t      r;
    park = (method_q == METHOD_PARK);
    segs = (method_q == METHOD_MINN) ? 2 : 1;
    l    = (method_q == METHOD_MINN) ? n / 4 : n / 2;
    pr = 0; pi = 0; en = 0;
    for (int k = 0; k < segs; k++) begin
      for (int i = 0; i < l; i++) begin
        if (park) begin
          a = l - 1 - i;
          b = l + i;
        end else begin
          a = 2 * k * l + i;
          b = a + l;
        end
        ar = win_re[a]; ai = win_im[a]; br = win_re[b]; bi = win_im[b];
        if (park) begin
          pr += ar * br - ai * bi;
          pi += ar * bi + ai * br;
        end else begin
          pr += ar * br + ai * bi;
          pi += ar * bi - ai * br;
        end
        en += br * br + bi * bi;
      end
    end
    if (en == 0) begin
      r.value = '1;
      r.zero  = 1'b1;
      return r;
    end
    ur  = (pr < 0) ? -pr : pr;
    ui  = (pi < 0) ? -pi : pi;
    num = (ur * ur + ui * ui) << 16;
    den = 128'(en) * 128'(en);
    q   = num / den;
    r.value = (q > 128'hFFFFFF) ? '1 : q[METRIC_W-1:0];
    r.zero  = 1'b0;
    return r;
  endfunction

  task automatic report(string what, longint unsigned exp, longint unsigned got);
    $display("%0t ns: %s: expected %0d, got %0d", $time, what, exp, got);
    fail_count++;
  endtask

  always @(posedge clk) begin
    int      n, need;
    bit      park;
    metric_t got, exp;
    if (rst) begin
      method_q = METHOD_SC;
      size_q   = 10'd64;
      fill_q   = 0;
      awaited_metrics.delete();
    end else begin
      // any listed register write restarts the fill
      if (cfg_we) begin
        if (cfg_index == REG_METHOD) begin
          method_q = cfg_data[1:0];
          fill_q   = 0;
        end else if (cfg_index == REG_PREAMBLE_LEN) begin
          size_q = cfg_data;
          fill_q = 0;
        end
      end
      if (in_valid && in_ready) begin
        n    = block_len();
        park = (method_q == METHOD_PARK);
        need = park ? n + 1 : n;
        if (fill_q < need) begin
          win_re[fill_q] = sample_re;
          win_im[fill_q] = sample_im;
          fill_q++;
          if (!park && fill_q == need)
            awaited_metrics.insert(awaited_metrics.size(), window_metric(n));
        end else begin
          // Park scores the window before the shift, the others after it
          if (park) awaited_metrics.insert(awaited_metrics.size(), window_metric(n));
          for (int i = 0; i < need - 1; i++) begin
            win_re[i] = win_re[i + 1];
            win_im[i] = win_im[i + 1];
          end
          win_re[need - 1] = sample_re;
          win_im[need - 1] = sample_im;
          if (!park) awaited_metrics.insert(awaited_metrics.size(), window_metric(n));
        end
      end
      if (out_valid && out_ready) begin
        got.value = metric;
        got.zero  = zero_energy;
        if (awaited_metrics.size() == 0) begin
          report("unexpected result, metric", 0, got.value);
        end else begin
          exp = awaited_metrics.pop_front();
          if (got.value !== exp.value) report("metric", exp.value, got.value);
          if (got.zero !== exp.zero) report("zero_energy", exp.zero, got.zero);
        end
      end
    end
    pending = awaited_metrics.size();
  end

endmodule

// File: tb/sv/preamble_timing_metric_test.sv
// Testbench top: stimulus, output stalls and verdict for the preamble timing metric.
`timescale 1ns / 1ps
module preamble_timing_metric_test;
  import ptm_pkg::*;

  // method code with no name of its own: behaves as Schmidl-Cox
  localparam logic [1:0] METHOD_SPARE = 2'd3;
  // register indexes beyond the list: writes to them are ignored
  localparam logic [1:0] REG_SPARE_LO = 2'd2;
  localparam logic [1:0] REG_SPARE_HI = 2'd3;
  // allow well over the worst time from a sample to its metric
  localparam int SETTLE = 400;

  logic                          clk       = 1'b0;
  logic                          rst       = 1'b1;
  logic                          cfg_we    = 1'b0;
  logic [1:0]                    cfg_index = '0;
  logic [9:0]                    cfg_data  = '0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_BITS-1:0] sample_re = '0;
  logic signed [SAMPLE_BITS-1:0] sample_im = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [METRIC_W-1:0]           metric;
  logic                          zero_energy;
  int                            fail_count;
  int                            pending;

  bit in_gaps;      // sender idles between items
  bit out_stalls;   // receiver stalls between results
  int stall_left = 0;
  int total = 0;    // input transfers so far

  preamble_timing_metric u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .sample_re, .sample_im,
    .out_valid, .out_ready, .metric, .zero_energy
  );

  ptm_metric_checker u_check (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .sample_re, .sample_im,
    .out_valid, .out_ready, .metric, .zero_energy,
    .fail_count, .pending
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Hard limit: far beyond the slowest correct run.
  initial begin
    #4000000;
    $display("preamble_timing_metric: mismatch");
    $finish;
  end

  // Receiver: after each transfer draw a random stall, possibly zero; a zero stall
  // keeps ready high so back-to-back transfers stay possible.
  always @(posedge clk) begin
    int s;
    if (rst) begin
      out_ready  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      if (stall_left == 1) out_ready <= 1'b1;
    end else if (out_ready && out_valid) begin
      s = out_stalls ? $urandom_range(0, 18) : 0;
      if (s != 0) begin
        out_ready  <= 1'b0;
        stall_left <= s;
      end
    end else if (!out_ready) begin
      out_ready <= 1'b1;
    end
  end

  // Drop valid, then write a register once every awaited metric has come and
  // the block has had time to finish any work that yields no result.
  task automatic write_reg(logic [1:0] idx, logic [9:0] data);
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one sample and hold it until the transfer; valid only drops when a
  // gap follows, so it is never lowered and raised in one step.
  task automatic send(logic [15:0] re, logic [15:0] im);
    int gap;
    gap = in_gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    sample_re <= re;
    sample_im <= im;
    do @(posedge clk); while (!in_ready);
    total++;
  endtask

  // Mix of zeros, extremes, full-range and scaled-down values; scaled values
  // make lopsided windows that drive the metric into saturation.
  function automatic logic [15:0] pick_sample(bit quiet);
    logic signed [15:0] v;
    if (quiet && $urandom_range(0, 15) != 0) return '0;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      2, 3, 4: v = 16'($urandom);
      default: begin
        v = 16'($urandom);
        v = v >>> $urandom_range(0, 15);
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [1:0] m;
    logic [9:0] bs;
    int         r, n, count;
    bit         quiet;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: smallest window in each method, zero energy, extremes.
    in_gaps    = 1'b0;
    out_stalls = 1'b0;
    write_reg(REG_PREAMBLE_LEN, 10'd4);
    repeat (4) send(16'h0000, 16'h0000);
    send(16'h7FFF, 16'h8000);
    send(16'h8000, 16'h7FFF);
    send(16'h8000, 16'h8000);
    send(16'h7FFF, 16'h7FFF);

    write_reg(REG_METHOD, {8'h00, METHOD_MINN});
    send(16'h8000, 16'h8000);
    send(16'h7FFF, 16'h8000);
    send(16'h8000, 16'h7FFF);
    send(16'h7FFF, 16'h7FFF);
    send(16'h0000, 16'h0000);
    send(16'h8000, 16'h0001);

    // Park: a tiny second half against a full-scale first half saturates
    write_reg(REG_METHOD, {8'hFF, METHOD_PARK});
    send(16'h8000, 16'h8000);
    send(16'h7FFF, 16'h7FFF);
    send(16'h0001, 16'h0000);
    send(16'h0000, 16'h0001);
    send(16'h0000, 16'h0000);
    send(16'h7FFF, 16'h8000);
    send(16'h0000, 16'h0000);

    // Largest window once: length above the limit clamps to the maximum.
    write_reg(REG_METHOD, {8'h00, METHOD_SC});
    write_reg(REG_PREAMBLE_LEN, 10'h3FF);
    in_gaps    = 1'b1;
    out_stalls = 1'b1;
    for (int i = 0; i < MAX_BLOCK + 3; i++) send(pick_sample(1'b0), pick_sample(1'b0));

    // Random phases, mostly small windows, until the item budget is spent.
    while (total < 600) begin
      m = ($urandom_range(0, 9) == 0) ? METHOD_SPARE : 2'($urandom_range(0, 2));
      r = $urandom_range(0, 19);
      if (r < 3)       bs = 10'($urandom_range(0, 3));
      else if (r < 16) bs = 10'($urandom_range(4, 24));
      else             bs = 10'($urandom_range(25, 130));
      write_reg(REG_METHOD, {8'($urandom), m});
      write_reg(REG_PREAMBLE_LEN, bs);
      if ($urandom_range(0, 3) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI, 10'($urandom));
      in_gaps    = ($urandom_range(0, 3) != 0);
      out_stalls = ($urandom_range(0, 3) != 0);
      quiet      = ($urandom_range(0, 9) == 0);
      n = (bs < 4) ? 4 : bs;
      n = (m == METHOD_MINN) ? (n & ~3) : (n & ~1);
      count = n + 1 + $urandom_range(3, 30);
      for (int i = 0; i < count; i++) send(pick_sample(quiet), pick_sample(quiet));
    end
    in_valid <= 1'b0;

    // Drain, then give the block time to show any stray result.
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("preamble_timing_metric: match");
    end else begin
      $display("preamble_timing_metric: mismatch");
    end
    $finish;
  end

endmodule
